/* rtl/amt_pkg.sv */
// Shared types, constants and register codes for the adaptive mean threshold block.
// No dependencies; amt_div and adaptive_mean_threshold import this package.
package amt_pkg;

  // Geometry limits and the size of the circular line store.
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_RADIUS  = 7;
  localparam int STORE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field and counter widths.
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 11;
  localparam int RAD_W     = 3;
  localparam int GAIN_W    = 8;
  localparam int SUM_W     = 16;
  localparam int AREA_W    = 8;
  localparam int PIXCNT_W  = 21;
  localparam int CNT_W     = 22;
  localparam int LAG_W     = 13;
  localparam int POS_W     = 13;
  localparam int STEP_W    = ADDR_W + 2;
  localparam int LOOP_W    = 4;

  // Register map, indexed by paddr[3:2].
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_RADIUS = 2'd0;
  localparam reg_idx_t REG_GAIN   = 2'd1;
  localparam reg_idx_t REG_WIDTH  = 2'd2;
  localparam reg_idx_t REG_HEIGHT = 2'd3;

  // Register reset values and the geometry derived from them.
  localparam logic [RAD_W-1:0]    RST_RADIUS = 3'd2;
  localparam logic [GAIN_W-1:0]   RST_GAIN   = 8'd24;
  localparam logic [DIM_W-1:0]    RST_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0]    RST_HEIGHT = 11'd480;
  localparam logic [PIXCNT_W-1:0] RST_PIXELS = 21'd307200;
  localparam logic [LAG_W-1:0]    RST_LAG    = 13'd1282;
  localparam logic [CNT_W-1:0]    RST_TOTAL  = 22'd308482;
  localparam logic [AREA_W-1:0]   RST_AREA   = 8'd25;

  localparam logic [PIX_W-1:0] FG_VALUE = 8'd255;
  localparam logic [PIX_W-1:0] BG_VALUE = 8'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LATCH,
    ST_GEOM,
    ST_PREP,
    ST_READ,
    ST_TAIL,
    ST_DSTART,
    ST_DIV,
    ST_CMP,
    ST_OUT
  } amt_state_t;

  // Divider request and response.
  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [AREA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/amt_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module amt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/amt_div.sv */
// Radix-2 restoring divider: window sum over box area, one quotient bit per cycle.
// Depends on amt_pkg.
module amt_div (
  input  logic             clk,
  input  logic             rst_n,
  input  amt_pkg::div_req_t req,
  output amt_pkg::div_rsp_t rsp
);
  import amt_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [LOOP_W-1:0]     cnt_r, cnt_nxt;
  logic [AREA_W:0]       rem_r, rem_nxt;
  logic [SUM_W-1:0]      quo_r, quo_nxt;
  logic [AREA_W-1:0]     div_r, div_nxt;
  logic [AREA_W:0]       trial;

  // One shift and trial subtraction per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    trial    = {rem_r[AREA_W-1:0], quo_r[SUM_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = trial - {1'b0, div_r};
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LOOP_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[PIX_W-1:0];

endmodule

/* rtl/adaptive_mean_threshold.sv */
// Adaptive mean threshold over a square box window; top level of the block.
// Depends on amt_pkg, amt_ram and amt_div.
//
// Pixels arrive in raster order and are written into a circular line store; once the
// input is radius rows and radius pixels past a centre, that centre's box (pixels outside
// the image count as zero, the sum is always divided by the full (2r+1)^2 area) is read
// back one pixel per cycle through the store's single read port, the sum goes through a
// one-bit-per-cycle divider, and the pixel is compared with gain (unsigned 4.4) times the
// mean to give 255 or 0. An item that yields a result passes the window read loop and the
// divider; an item that yields none returns to idle after the prepare state, and the first
// item of a frame first passes the latch and geometry states. Each frame takes W*H pixels
// followed by r*W + r flush items. The line store needs no clearing pass.
module adaptive_mean_threshold (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [amt_pkg::PIX_W-1:0]   in_pixel,
  input  logic                        in_drain,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [amt_pkg::PIX_W-1:0]   out_value,
  output logic                        out_last_of_frame,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import amt_pkg::*;

  amt_state_t state_r, state_nxt;

  logic [RAD_W-1:0]    radius_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [DIM_W-1:0]    fwidth_r, fheight_r;

  logic [DIM_W-1:0]    lat_w_r, lat_w_nxt, lat_h_r, lat_h_nxt;
  logic [RAD_W-1:0]    lat_r_r, lat_r_nxt;
  logic [PIXCNT_W-1:0] pixels_r, pixels_nxt;
  logic [LAG_W-1:0]    lag_r, lag_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [AREA_W-1:0]   area_r, area_nxt;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   wp_r, wp_nxt, caddr_r, caddr_nxt, addr_r, addr_nxt;
  logic [DIM_W-1:0]    ci_r, ci_nxt, cj_r, cj_nxt;
  logic [PIX_W-1:0]    pix_r, pix_nxt;
  logic                drain_r, drain_nxt;
  logic [POS_W-1:0]    y_r, y_nxt, x_r, x_nxt;
  logic [LOOP_W-1:0]   acnt_r, acnt_nxt, bcnt_r, bcnt_nxt;
  logic                tagv_r, tagv_nxt, tagc_r, tagc_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [PIX_W-1:0]    centre_r, centre_nxt;
  logic                fg_r, fg_nxt;
  logic                outv_r, outv_nxt, outlast_r, outlast_nxt;
  logic [PIX_W-1:0]    outval_r, outval_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [PIX_W-1:0]    ram_rdata;
  div_req_t            dreq;
  div_rsp_t            drsp;

  logic                bump, out_load, cfg_wr, in_bounds;
  logic [CNT_W-1:0]    cnt_inc;
  logic [LOOP_W-1:0]   span;
  logic [2*DIM_W-1:0]  pix_prod;
  logic [RAD_W:0]      side;
  logic [GAIN_W+PIX_W-1:0] thr;
  logic signed [STEP_W-1:0] row_step;

  // Brings an address that has moved by less than the store depth back into range.
  function automatic logic [ADDR_W-1:0] wrap_addr(input logic signed [STEP_W-1:0] v);
    logic signed [STEP_W-1:0] d;
    d = STEP_W'(STORE_DEPTH);
    if (v < 0) begin
      return ADDR_W'(v + d);
    end else if (v >= d) begin
      return ADDR_W'(v - d);
    end
    return ADDR_W'(v);
  endfunction

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= RST_RADIUS;
      gain_r    <= RST_GAIN;
      fwidth_r  <= RST_WIDTH;
      fheight_r <= RST_HEIGHT;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_RADIUS: radius_r  <= pwdata[RAD_W-1:0];
        REG_GAIN:   gain_r    <= pwdata[GAIN_W-1:0];
        REG_WIDTH:  fwidth_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: fheight_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_RADIUS: prdata = {29'b0, radius_r};
      REG_GAIN:   prdata = {24'b0, gain_r};
      REG_WIDTH:  prdata = {21'b0, fwidth_r};
      REG_HEIGHT: prdata = {21'b0, fheight_r};
      default:    prdata = '0;
    endcase
  end

  // Line store and divider.
  amt_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (pix_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign dreq.start    = (state_r == ST_DSTART);
  assign dreq.dividend = sum_r;
  assign dreq.divisor  = area_r;

  amt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = outv_r;
  assign out_value         = outval_r;
  assign out_last_of_frame = outlast_r;

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt   = state_r;
    lat_w_nxt   = lat_w_r;
    lat_h_nxt   = lat_h_r;
    lat_r_nxt   = lat_r_r;
    pixels_nxt  = pixels_r;
    lag_nxt     = lag_r;
    total_nxt   = total_r;
    area_nxt    = area_r;
    cnt_nxt     = cnt_r;
    wp_nxt      = wp_r;
    caddr_nxt   = caddr_r;
    addr_nxt    = addr_r;
    ci_nxt      = ci_r;
    cj_nxt      = cj_r;
    pix_nxt     = pix_r;
    drain_nxt   = drain_r;
    y_nxt       = y_r;
    x_nxt       = x_r;
    acnt_nxt    = acnt_r;
    bcnt_nxt    = bcnt_r;
    tagv_nxt    = 1'b0;
    tagc_nxt    = 1'b0;
    sum_nxt     = sum_r;
    centre_nxt  = centre_r;
    fg_nxt      = fg_r;
    outv_nxt    = outv_r && !out_ready;
    outval_nxt  = outval_r;
    outlast_nxt = outlast_r;
    ram_we      = 1'b0;
    ram_raddr   = addr_r;
    bump        = 1'b0;
    out_load    = 1'b0;
    cnt_inc     = cnt_r + 1'b1;
    span        = {lat_r_r, 1'b0};
    pix_prod    = {{DIM_W{1'b0}}, lat_w_r} * {{DIM_W{1'b0}}, lat_h_r};
    side        = {lat_r_r, 1'b1};
    thr         = gain_r * drsp.quotient;
    row_step    = $signed({{(STEP_W-DIM_W){1'b0}}, lat_w_r})
                - $signed({{(STEP_W-RAD_W-1){1'b0}}, lat_r_r, 1'b0});
    in_bounds   = !y_r[POS_W-1] && (y_r[POS_W-2:0] < {1'b0, lat_h_r})
               && !x_r[POS_W-1] && (x_r[POS_W-2:0] < {1'b0, lat_w_r});

    // Window pixels come back in the cycle after their read.
    if (tagv_r) begin
      sum_nxt = sum_r + {{(SUM_W-PIX_W){1'b0}}, ram_rdata};
    end
    if (tagc_r) begin
      centre_nxt = ram_rdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pix_nxt   = in_pixel;
          drain_nxt = in_drain;
          state_nxt = (cnt_r == '0) ? ST_LATCH : ST_PREP;
        end
      end
      ST_LATCH: begin
        lat_w_nxt = fwidth_r;
        if (fwidth_r == '0) begin
          lat_w_nxt = DIM_W'(1);
        end else if (fwidth_r > DIM_W'(MAX_WIDTH)) begin
          lat_w_nxt = DIM_W'(MAX_WIDTH);
        end
        lat_h_nxt = (fheight_r == '0) ? DIM_W'(1) : fheight_r;
        lat_r_nxt = (radius_r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_r;
        state_nxt = ST_GEOM;
      end
      ST_GEOM: begin
        pixels_nxt = pix_prod[PIXCNT_W-1:0];
        lag_nxt    = {{(LAG_W-RAD_W){1'b0}}, lat_r_r} * {{(LAG_W-DIM_W){1'b0}}, lat_w_r}
                   + {{(LAG_W-RAD_W){1'b0}}, lat_r_r};
        total_nxt  = {1'b0, pix_prod[PIXCNT_W-1:0]} + {{(CNT_W-LAG_W){1'b0}}, lag_nxt};
        area_nxt   = {{(AREA_W-RAD_W-1){1'b0}}, side} * {{(AREA_W-RAD_W-1){1'b0}}, side};
        state_nxt  = ST_PREP;
      end
      ST_PREP: begin
        if ((cnt_r < {1'b0, pixels_r}) && drain_r) begin
          // A drain before the frame's last pixel is dropped.
          state_nxt = ST_IDLE;
        end else begin
          if (cnt_r < {1'b0, pixels_r}) begin
            ram_we = 1'b1;
            wp_nxt = (wp_r == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
          end
          if (cnt_r >= {{(CNT_W-LAG_W){1'b0}}, lag_r}) begin
            y_nxt     = POS_W'({2'b0, ci_r}) - POS_W'({{(POS_W-RAD_W){1'b0}}, lat_r_r});
            x_nxt     = POS_W'({2'b0, cj_r}) - POS_W'({{(POS_W-RAD_W){1'b0}}, lat_r_r});
            acnt_nxt  = '0;
            bcnt_nxt  = '0;
            sum_nxt   = '0;
            addr_nxt  = wrap_addr($signed({2'b0, caddr_r})
                                - $signed({{(STEP_W-LAG_W){1'b0}}, lag_r}));
            state_nxt = ST_READ;
          end else begin
            bump      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        tagv_nxt = in_bounds;
        tagc_nxt = (y_r == POS_W'({2'b0, ci_r})) && (x_r == POS_W'({2'b0, cj_r}));
        if (bcnt_r == span) begin
          bcnt_nxt = '0;
          if (acnt_r == span) begin
            state_nxt = ST_TAIL;
          end else begin
            acnt_nxt = acnt_r + 1'b1;
            y_nxt    = y_r + 1'b1;
            x_nxt    = POS_W'({2'b0, cj_r}) - POS_W'({{(POS_W-RAD_W){1'b0}}, lat_r_r});
            addr_nxt = wrap_addr($signed({2'b0, addr_r}) + row_step);
          end
        end else begin
          bcnt_nxt = bcnt_r + 1'b1;
          x_nxt    = x_r + 1'b1;
          addr_nxt = (addr_r == ADDR_W'(STORE_DEPTH - 1)) ? '0 : addr_r + 1'b1;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (drsp.done) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        fg_nxt    = {4'b0, centre_r, 4'b0} > thr;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!outv_r || out_ready) begin
          out_load    = 1'b1;
          outv_nxt    = 1'b1;
          outval_nxt  = fg_r ? FG_VALUE : BG_VALUE;
          outlast_nxt = (cnt_inc == total_r);
          caddr_nxt   = (caddr_r == ADDR_W'(STORE_DEPTH - 1)) ? '0 : caddr_r + 1'b1;
          if (cj_r + 1'b1 == lat_w_r) begin
            cj_nxt = '0;
            ci_nxt = ci_r + 1'b1;
          end else begin
            cj_nxt = cj_r + 1'b1;
          end
          bump      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Item finished: advance the frame counter, rewind at the end of the frame.
    if (bump) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc >= total_r) begin
        cnt_nxt   = '0;
        wp_nxt    = '0;
        caddr_nxt = '0;
        ci_nxt    = '0;
        cj_nxt    = '0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      lat_w_r  <= RST_WIDTH;
      lat_h_r  <= RST_HEIGHT;
      lat_r_r  <= RST_RADIUS;
      pixels_r <= RST_PIXELS;
      lag_r    <= RST_LAG;
      total_r  <= RST_TOTAL;
      area_r   <= RST_AREA;
      cnt_r    <= '0;
      wp_r     <= '0;
      caddr_r  <= '0;
      ci_r     <= '0;
      cj_r     <= '0;
      tagv_r   <= 1'b0;
      tagc_r   <= 1'b0;
      outv_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      lat_w_r  <= lat_w_nxt;
      lat_h_r  <= lat_h_nxt;
      lat_r_r  <= lat_r_nxt;
      pixels_r <= pixels_nxt;
      lag_r    <= lag_nxt;
      total_r  <= total_nxt;
      area_r   <= area_nxt;
      cnt_r    <= cnt_nxt;
      wp_r     <= wp_nxt;
      caddr_r  <= caddr_nxt;
      ci_r     <= ci_nxt;
      cj_r     <= cj_nxt;
      tagv_r   <= tagv_nxt;
      tagc_r   <= tagc_nxt;
      outv_r   <= outv_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    pix_r     <= pix_nxt;
    drain_r   <= drain_nxt;
    y_r       <= y_nxt;
    x_r       <= x_nxt;
    acnt_r    <= acnt_nxt;
    bcnt_r    <= bcnt_nxt;
    sum_r     <= sum_nxt;
    centre_r  <= centre_nxt;
    fg_r      <= fg_nxt;
    outval_r  <= outval_nxt;
    outlast_r <= outlast_nxt;
  end

  // The frame counter never passes the frame length while waiting for a transaction.
  a_cnt_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r < total_r))
    else $error("frame counter beyond frame length");

  // Store pointers stay inside the circular line store.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r < ADDR_W'(STORE_DEPTH)) && (caddr_r < ADDR_W'(STORE_DEPTH)))
    else $error("line store pointer out of range");

  // Loading the frame's last result rewinds the frame.
  a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && outlast_nxt) |=> (cnt_r == '0) && (wp_r == '0))
    else $error("frame did not rewind after its last result");

  // Window tags come only from the read loop.
  a_tags_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    tagv_r |-> ($past(state_r) == ST_READ))
    else $error("window tag outside the read loop");

endmodule

/* test/adaptive_mean_threshold_tb.sv */
// Self-checking testbench for the adaptive mean threshold block.
// Depends on amt_pkg and the adaptive_mean_threshold RTL; reads no files.
`timescale 1ns / 100ps

module adaptive_mean_threshold_tb;
  import amt_pkg::*;

  localparam int LIMIT = 4000000;
  localparam int SETTLE = 300;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             drain;
  } pix_item_t;

  typedef struct {
    logic [PIX_W-1:0] value;
    logic             last;
  } thr_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PIX_W-1:0] in_pixel = '0;
  logic in_drain = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PIX_W-1:0] out_value;
  logic out_last_of_frame;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pix_item_t   pending_pixels[$];
  thr_result_t expected_results[$];

  int errors = 0;
  int results_seen = 0;
  int frames_sent = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_trigger = 1'b0;
  bit hold_done = 1'b0;
  int hold_count = 0;

  // Shadow of the block: registers, latched geometry and frame progress.
  logic [PIX_W-1:0] shadow_store[STORE_DEPTH];
  logic [RAD_W-1:0]  reg_radius = RST_RADIUS;
  logic [GAIN_W-1:0] reg_gain = RST_GAIN;
  logic [DIM_W-1:0]  reg_width = RST_WIDTH;
  logic [DIM_W-1:0]  reg_height = RST_HEIGHT;
  int frame_w = 640, frame_h = 480, frame_r = 2;
  int frame_pos = 0, row_pos = 0, col_pos = 0;

  adaptive_mean_threshold dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel), .in_drain(in_drain),
    .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
    .out_last_of_frame(out_last_of_frame),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sum of the box around a centre; pixels outside the frame count as zero.
  function automatic int box_total(int ci, int cj);
    int s;
    s = 0;
    for (int y = ci - frame_r; y <= ci + frame_r; y++)
      for (int x = cj - frame_r; x <= cj + frame_r; x++)
        if (y >= 0 && y < frame_h && x >= 0 && x < frame_w)
          s += shadow_store[(y * frame_w + x) % STORE_DEPTH];
    return s & 16'hFFFF;
  endfunction

  // Advances the shadow by one accepted transaction and queues any result it yields.
  task automatic predict_threshold(pix_item_t it);
    int pixels, lag, q, area, mean;
    thr_result_t res;
    if (frame_pos == 0) begin
      frame_w = (reg_width == 0) ? 1 : (reg_width > MAX_WIDTH ? MAX_WIDTH : int'(reg_width));
      frame_h = (reg_height == 0) ? 1 : int'(reg_height);
      frame_r = reg_radius;
    end
    pixels = frame_w * frame_h;
    lag = frame_r * frame_w + frame_r;
    if (frame_pos < pixels) begin
      if (it.drain) return;
      shadow_store[(row_pos * frame_w + col_pos) % STORE_DEPTH] = it.pixel;
      col_pos++;
      if (col_pos >= frame_w) begin
        col_pos = 0;
        row_pos++;
      end
    end
    if (frame_pos >= lag) begin
      q = frame_pos - lag;
      area = (2 * frame_r + 1) * (2 * frame_r + 1);
      mean = box_total(q / frame_w, q % frame_w) / area;
      res.value = (shadow_store[q % STORE_DEPTH] * 16 > reg_gain * mean) ? FG_VALUE : BG_VALUE;
      res.last = (q == pixels - 1);
      expected_results.push_back(res);
    end
    frame_pos++;
    if (frame_pos >= pixels + lag) begin
      frame_pos = 0;
      row_pos = 0;
      col_pos = 0;
    end
  endtask

  // Input driver: offers the next pending pixel when the slot is free, idling at random by send_idle_pct.
  always @(posedge clk) begin
    if (rst_n && (!in_valid || in_ready)) begin
      if (in_valid) predict_threshold('{in_pixel, in_drain});
      if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_pixel <= pending_pixels[0].pixel;
        in_drain <= pending_pixels[0].drain;
        void'(pending_pixels.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, including one long hold-off.
  always @(posedge clk) begin
    if (hold_trigger && !hold_done) begin
      out_ready <= 1'b0;
      hold_count++;
      if (hold_count >= 600) hold_done = 1'b1;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    thr_result_t exp_r;
    if (out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%0d last=%0b", $time, out_value,
                 out_last_of_frame);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_value !== exp_r.value) begin
          errors++;
          $display("%0t: value expected %0d actual %0d", $time, exp_r.value, out_value);
        end
        if (out_last_of_frame !== exp_r.last) begin
          errors++;
          $display("%0t: last_of_frame expected %0b actual %0b", $time, exp_r.last,
                   out_last_of_frame);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Register write over the configuration port; the shadow follows at the access edge.
  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RADIUS: reg_radius = val[RAD_W-1:0];
      REG_GAIN:   reg_gain = val[GAIN_W-1:0];
      REG_WIDTH:  reg_width = val[DIM_W-1:0];
      REG_HEIGHT: reg_height = val[DIM_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every sent transaction is accepted and answered, then lets the block settle.
  task automatic wait_idle();
    while (pending_pixels.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Programs the geometry and gain, then queues one whole frame and its flush transactions.
  task automatic send_frame(int r, int g, int w, int h, int style);
    int ew, eh, npix;
    wait_idle();
    cfg_write(REG_RADIUS, r);
    cfg_write(REG_GAIN, g);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    ew = (w == 0) ? 1 : (w > MAX_WIDTH ? MAX_WIDTH : w);
    eh = (h == 0) ? 1 : h;
    npix = 0;
    while (npix < ew * eh) begin
      // A drain mid-frame must be ignored by the block.
      if ($urandom_range(15) == 0)
        pending_pixels.push_back('{PIX_W'($urandom), 1'b1});
      case (style)
        0: pending_pixels.push_back('{PIX_W'($urandom), 1'b0});
        1: pending_pixels.push_back('{($urandom_range(1) ? FG_VALUE : BG_VALUE), 1'b0});
        default: pending_pixels.push_back('{PIX_W'($urandom_range(90, 130)), 1'b0});
      endcase
      npix++;
    end
    for (int k = 0; k < r * ew + r; k++)
      pending_pixels.push_back('{PIX_W'($urandom), 1'($urandom)});
    frames_sent++;
  endtask

  initial begin
    int sent_mark, r;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames: pixel extremes, gain extremes, largest radius and clamped geometry.
    send_frame(1, 16, 4, 3, 1);
    send_frame(0, 0, 1, 1, 1);
    send_frame(0, 255, 1, 1, 1);
    send_frame(7, 255, 3, 2, 0);
    send_frame(5, 128, 0, 0, 0);
    send_frame(0, 170, 2047, 1, 0);
    send_frame(0, 85, 1, 64, 2);

    // Random frames over four idling phases; one long receiver hold-off early on.
    sent_mark = frames_sent;
    for (int n = 0; n < 350; ) begin
      case ((n * 4) / 350)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      r = ($urandom_range(3) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
      send_frame(r, $urandom_range(255), $urandom_range(1, 12), $urandom_range(1, 8),
                 $urandom_range(2));
      if (frames_sent - sent_mark == 2) hold_trigger = 1'b1;
      n += pending_pixels.size();
    end
    wait_idle();

    $display("Covered %0d frames and %0d thresholded pixels over four idling phases,",
             frames_sent, results_seen);
    $display("with radius 0 to 7, gain extremes and clamped width and height.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, expected_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
